// ===== sv/kftl_pkg.sv =====
`default_nettype none
package kftl_pkg;

  localparam int REQ_TYPE_W   = 2;
  localparam int KEY_INDEX_W  = 6;
  localparam int KEY_TIME_W   = 32;
  localparam int DELTA_W      = 32;
  localparam int KEY_OUT_W    = 7;
  localparam int FRAC_W       = 16;
  localparam int SPEED_W      = 16;
  localparam int STEP_W       = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int PROD_W       = DELTA_W + SPEED_W;
  localparam int SPEED_FRAC_W = 8;

  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_ADVANCE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_RESTART = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_STEP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ENABLE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED       = 2'd3;

  localparam logic [KEY_OUT_W-1:0] NONE_INDEX = 7'h7f;
  localparam logic [FRAC_W-1:0]    FRAC_SAT   = 16'hffff;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ADVANCE,
    CMD_RESTART,
    CMD_NONE
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [KEY_INDEX_W-1:0] key_index;
    logic [KEY_TIME_W-1:0]  key_time;
    logic [DELTA_W-1:0]     delta;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WRAP,
    ST_CHECK,
    ST_CMP_FIRST,
    ST_CMP_LAST,
    ST_PROBE,
    ST_CMP_PROBE,
    ST_CMP_IDX,
    ST_CMP_NEXT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== sv/keyframe_time_locator_top.sv =====
`default_nettype none
// Keyframe time locator. Load transactions fill a table of ascending key times and
// track the earliest and latest key; advance transactions move the play time by
// delta_time times speed, wrap or stop at the last key, and then binary-search the
// table for the bracketing keys and a Q0.16 blend fraction. Every transaction
// returns exactly one result. A two-entry queue sits between the input decoder and
// the execution sequencer, and a result register decouples the output side. Restart
// transactions return the play time to the earliest key, clear the finished flag and
// then advance by zero. Loads, advances of a finished clip, unknown requests and any
// advance or restart whose play time does not change skip the search. The single
// read port of the key memory, which serves one probe at a time with a compare state
// after each read, and the one-bit-per-cycle divider set the length of a search.
module keyframe_time_locator_top #(
  parameter int MAX_KEYS  = 64,
  parameter int TIME_BITS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [kftl_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [kftl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [kftl_pkg::REQ_TYPE_W-1:0]        in_req_type,
  input  wire logic [kftl_pkg::KEY_INDEX_W-1:0]       in_key_index,
  input  wire logic [kftl_pkg::KEY_TIME_W-1:0]        in_key_time,
  input  wire logic [kftl_pkg::DELTA_W-1:0]           in_delta_time,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [kftl_pkg::KEY_OUT_W-1:0]       out_left_key,
  output logic signed [kftl_pkg::KEY_OUT_W-1:0]       out_right_key,
  output logic [kftl_pkg::FRAC_W-1:0]                 out_blend_fraction,
  output logic                                        out_finished,
  output logic [kftl_pkg::KEY_TIME_W-1:0]             out_play_time
);

  logic           q_valid;
  kftl_pkg::req_t q_data;
  logic           q_pop;

  kftl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_key_index  (in_key_index),
    .in_key_time   (in_key_time),
    .in_delta_time (in_delta_time),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop)
  );

  kftl_back #(
    .MAX_KEYS  (MAX_KEYS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_key       (out_left_key),
    .out_right_key      (out_right_key),
    .out_blend_fraction (out_blend_fraction),
    .out_finished       (out_finished),
    .out_play_time      (out_play_time)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_empty_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !in_stall)
    else $error("input stalled with an empty queue");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_valid)
    else $error("accepted transaction not visible in queue");
`endif

endmodule
`default_nettype wire

// ===== sv/kftl_front.sv =====
`default_nettype none
module kftl_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [kftl_pkg::REQ_TYPE_W-1:0]    in_req_type,
  input  wire logic [kftl_pkg::KEY_INDEX_W-1:0]   in_key_index,
  input  wire logic [kftl_pkg::KEY_TIME_W-1:0]    in_key_time,
  input  wire logic [kftl_pkg::DELTA_W-1:0]       in_delta_time,
  output logic                                    q_valid,
  output kftl_pkg::req_t                          q_data,
  input  wire logic                               q_pop
);

  kftl_pkg::req_t entry_r [2];
  kftl_pkg::req_t req;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;

  always_comb begin
    req.key_index = in_key_index;
    req.key_time  = in_key_time;
    req.delta     = in_delta_time;
    case (in_req_type)
      kftl_pkg::REQ_LOAD:    req.cmd = kftl_pkg::CMD_LOAD;
      kftl_pkg::REQ_ADVANCE: req.cmd = kftl_pkg::CMD_ADVANCE;
      kftl_pkg::REQ_RESTART: begin
        req.cmd   = kftl_pkg::CMD_RESTART;
        req.delta = '0;
      end
      default:               req.cmd = kftl_pkg::CMD_NONE;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= req;
    end
  end

endmodule
`default_nettype wire

// ===== sv/kftl_back.sv =====
`default_nettype none
module kftl_back #(
  parameter int MAX_KEYS  = 64,
  parameter int TIME_BITS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [kftl_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [kftl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   q_valid,
  input  wire kftl_pkg::req_t                         q_data,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [kftl_pkg::KEY_OUT_W-1:0]       out_left_key,
  output logic signed [kftl_pkg::KEY_OUT_W-1:0]       out_right_key,
  output logic [kftl_pkg::FRAC_W-1:0]                 out_blend_fraction,
  output logic                                        out_finished,
  output logic [kftl_pkg::KEY_TIME_W-1:0]             out_play_time
);

  localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW     = $clog2(MAX_KEYS + 1);
  localparam int PW     = ((CW > kftl_pkg::STEP_W) ? CW : kftl_pkg::STEP_W) + 1;
  localparam int INC_W  = kftl_pkg::PROD_W - kftl_pkg::SPEED_FRAC_W;
  localparam int SUMW   = ((TIME_BITS > INC_W) ? TIME_BITS : INC_W) + 1;
  localparam int KIW    = kftl_pkg::KEY_INDEX_W + 1;
  localparam int KIC    = (KIW > CW) ? KIW : CW;

  logic [TIME_BITS-1:0] key_mem [MAX_KEYS];
  logic [TIME_BITS-1:0] rd_data_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  logic [kftl_pkg::KEY_OUT_W-1:0] key_count_r;
  logic [kftl_pkg::STEP_W-1:0]    search_step_r;
  logic                           loop_enable_r;
  logic [kftl_pkg::SPEED_W-1:0]   speed_r;

  kftl_pkg::state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]           cur_r, cur_nxt;
  logic [TIME_BITS-1:0]           prev_r, prev_nxt;
  logic                           prev_valid_r, prev_valid_nxt;
  logic                           done_r, done_nxt;
  logic [TIME_BITS-1:0]           start_r, start_nxt;
  logic [TIME_BITS-1:0]           stop_r, stop_nxt;
  logic                           seen_r, seen_nxt;
  logic [kftl_pkg::KEY_OUT_W-1:0] lower_r, lower_nxt;
  logic [kftl_pkg::KEY_OUT_W-1:0] upper_r, upper_nxt;
  logic [kftl_pkg::FRAC_W-1:0]    frac_r, frac_nxt;
  logic [kftl_pkg::DELTA_W-1:0]   del_r, del_nxt;
  logic [kftl_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [kftl_pkg::STEP_W-1:0]    stride_r, stride_nxt;
  logic [TIME_BITS-1:0]           kl_r, kl_nxt;
  logic [TIME_BITS:0]             rem_r, rem_nxt;
  logic [TIME_BITS-1:0]           den_r, den_nxt;
  logic [kftl_pkg::FRAC_W-1:0]    quo_r, quo_nxt;
  logic [3:0]                     div_cnt_r, div_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_load;

  logic [CW-1:0]        cnt;
  logic [PW-1:0]        probe;
  logic [TIME_BITS-1:0] ktime;
  logic [SUMW-1:0]      sum;
  logic [TIME_BITS-1:0] num;
  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS:0]   shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r   <= 7'd1;
      search_step_r <= 7'd32;
      loop_enable_r <= 1'b1;
      speed_r       <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        kftl_pkg::CFG_KEY_COUNT:   key_count_r   <= cfg_data[kftl_pkg::KEY_OUT_W-1:0];
        kftl_pkg::CFG_SEARCH_STEP: search_step_r <= cfg_data[kftl_pkg::STEP_W-1:0];
        kftl_pkg::CFG_LOOP_ENABLE: loop_enable_r <= cfg_data[0];
        kftl_pkg::CFG_SPEED:       speed_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_count_r == '0) begin
      cnt = CW'(1);
    end else if (PW'(key_count_r) > PW'(MAX_KEYS)) begin
      cnt = CW'(MAX_KEYS);
    end else begin
      cnt = CW'(key_count_r);
    end
  end

  assign probe     = PW'(idx_r) + PW'(stride_r);
  assign ktime     = TIME_BITS'(q_data.key_time);
  assign sum       = SUMW'(cur_r) + SUMW'(prod_r >> kftl_pkg::SPEED_FRAC_W);
  assign num       = cur_r - kl_r;
  assign den       = (rd_data_r > kl_r) ? (rd_data_r - kl_r) : '0;
  assign shifted   = {rem_r[TIME_BITS-1:0], 1'b0};
  assign mem_waddr = IDX_W'(q_data.key_index);
  assign mem_wdata = ktime;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    done_nxt       = done_r;
    start_nxt      = start_r;
    stop_nxt       = stop_r;
    seen_nxt       = seen_r;
    lower_nxt      = lower_r;
    upper_nxt      = upper_r;
    frac_nxt       = frac_r;
    del_nxt        = del_r;
    prod_nxt       = prod_r;
    idx_nxt        = idx_r;
    stride_nxt     = stride_r;
    kl_nxt         = kl_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    quo_nxt        = quo_r;
    div_cnt_nxt    = div_cnt_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_raddr      = '0;
    out_load       = 1'b0;
    case (state_r)
      kftl_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_data.cmd)
            kftl_pkg::CMD_LOAD: begin
              mem_we = (KIC'(q_data.key_index) < KIC'(MAX_KEYS));
              if (!seen_r) begin
                start_nxt = ktime;
                stop_nxt  = ktime;
                seen_nxt  = 1'b1;
              end else begin
                if (ktime < start_r) start_nxt = ktime;
                if (ktime > stop_r)  stop_nxt  = ktime;
              end
              state_nxt = kftl_pkg::ST_OUT;
            end
            kftl_pkg::CMD_ADVANCE: begin
              if (done_r) begin
                state_nxt = kftl_pkg::ST_OUT;
              end else begin
                del_nxt   = q_data.delta;
                state_nxt = kftl_pkg::ST_MUL;
              end
            end
            kftl_pkg::CMD_RESTART: begin
              cur_nxt   = start_r;
              done_nxt  = 1'b0;
              del_nxt   = q_data.delta;
              state_nxt = kftl_pkg::ST_MUL;
            end
            default: state_nxt = kftl_pkg::ST_OUT;
          endcase
        end
      end
      kftl_pkg::ST_MUL: begin
        prod_nxt  = del_r * speed_r;
        state_nxt = kftl_pkg::ST_ADD;
      end
      kftl_pkg::ST_ADD: begin
        if (sum > SUMW'({TIME_BITS{1'b1}})) begin
          cur_nxt = '1;
        end else begin
          cur_nxt = TIME_BITS'(sum);
        end
        state_nxt = kftl_pkg::ST_WRAP;
      end
      kftl_pkg::ST_WRAP: begin
        if (cur_r >= stop_r) begin
          if (loop_enable_r) begin
            cur_nxt = cur_r - stop_r + start_r;
          end else begin
            done_nxt = 1'b1;
            cur_nxt  = stop_r;
          end
        end
        state_nxt = kftl_pkg::ST_CHECK;
      end
      kftl_pkg::ST_CHECK: begin
        if (prev_valid_r && prev_r == cur_r) begin
          state_nxt = kftl_pkg::ST_OUT;
        end else begin
          prev_nxt       = cur_r;
          prev_valid_nxt = 1'b1;
          frac_nxt       = '0;
          if (cnt == CW'(1)) begin
            lower_nxt = '0;
            upper_nxt = '0;
            state_nxt = kftl_pkg::ST_OUT;
          end else begin
            mem_raddr = '0;
            state_nxt = kftl_pkg::ST_CMP_FIRST;
          end
        end
      end
      kftl_pkg::ST_CMP_FIRST: begin
        if (rd_data_r >= cur_r) begin
          lower_nxt = '0;
          upper_nxt = kftl_pkg::NONE_INDEX;
          state_nxt = kftl_pkg::ST_OUT;
        end else begin
          mem_raddr = IDX_W'(cnt - CW'(1));
          state_nxt = kftl_pkg::ST_CMP_LAST;
        end
      end
      kftl_pkg::ST_CMP_LAST: begin
        if (rd_data_r <= cur_r) begin
          lower_nxt = kftl_pkg::NONE_INDEX;
          upper_nxt = kftl_pkg::KEY_OUT_W'(cnt - CW'(1));
          state_nxt = kftl_pkg::ST_OUT;
        end else begin
          idx_nxt    = '0;
          stride_nxt = search_step_r;
          state_nxt  = kftl_pkg::ST_PROBE;
        end
      end
      kftl_pkg::ST_PROBE: begin
        if (stride_r == '0) begin
          mem_raddr = idx_r;
          state_nxt = kftl_pkg::ST_CMP_IDX;
        end else if (probe < PW'(cnt)) begin
          mem_raddr = IDX_W'(probe);
          state_nxt = kftl_pkg::ST_CMP_PROBE;
        end else begin
          stride_nxt = stride_r >> 1;
        end
      end
      kftl_pkg::ST_CMP_PROBE: begin
        if (rd_data_r <= cur_r) begin
          idx_nxt = IDX_W'(probe);
        end
        stride_nxt = stride_r >> 1;
        state_nxt  = kftl_pkg::ST_PROBE;
      end
      kftl_pkg::ST_CMP_IDX: begin
        lower_nxt = kftl_pkg::KEY_OUT_W'(idx_r);
        if (rd_data_r == cur_r) begin
          upper_nxt = kftl_pkg::KEY_OUT_W'(idx_r);
          state_nxt = kftl_pkg::ST_OUT;
        end else begin
          upper_nxt = kftl_pkg::KEY_OUT_W'(idx_r + IDX_W'(1));
          kl_nxt    = rd_data_r;
          mem_raddr = idx_r + IDX_W'(1);
          state_nxt = kftl_pkg::ST_CMP_NEXT;
        end
      end
      kftl_pkg::ST_CMP_NEXT: begin
        if (num >= den) begin
          frac_nxt  = kftl_pkg::FRAC_SAT;
          state_nxt = kftl_pkg::ST_OUT;
        end else begin
          rem_nxt     = {1'b0, num};
          den_nxt     = den;
          quo_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = kftl_pkg::ST_DIV;
        end
      end
      kftl_pkg::ST_DIV: begin
        if (shifted >= {1'b0, den_r}) begin
          rem_nxt = shifted - {1'b0, den_r};
          quo_nxt = {quo_r[kftl_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          quo_nxt = {quo_r[kftl_pkg::FRAC_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd15) begin
          frac_nxt  = quo_nxt;
          state_nxt = kftl_pkg::ST_OUT;
        end
      end
      kftl_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = kftl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kftl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kftl_pkg::ST_IDLE;
      cur_r        <= '0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      done_r       <= 1'b0;
      start_r      <= '0;
      stop_r       <= '0;
      seen_r       <= 1'b0;
      lower_r      <= '0;
      upper_r      <= '0;
      frac_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      done_r       <= done_nxt;
      start_r      <= start_nxt;
      stop_r       <= stop_nxt;
      seen_r       <= seen_nxt;
      lower_r      <= lower_nxt;
      upper_r      <= upper_nxt;
      frac_r       <= frac_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    del_r     <= del_nxt;
    prod_r    <= prod_nxt;
    idx_r     <= idx_nxt;
    stride_r  <= stride_nxt;
    kl_r      <= kl_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (out_load) begin
      out_left_key       <= lower_r;
      out_right_key      <= upper_r;
      out_blend_fraction <= frac_r;
      out_finished       <= done_r;
      out_play_time      <= kftl_pkg::KEY_TIME_W'(cur_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= key_mem[mem_raddr];
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
